[sv/cac_pkg.sv]
// ----------------------------------------------------------------------------
// cac_pkg
// Shared constants and the arctangent table for the CORDIC atan2 core.
// ----------------------------------------------------------------------------
package cac_pkg;

  localparam int CAC_ITERATIONS  = 16;
  localparam int CAC_INPUT_WIDTH = 16;
  localparam int ANGLE_W         = 17;
  localparam int ANGLE_OUT_W     = 16;
  localparam int GUARD_BITS      = 3;

  localparam logic signed [ANGLE_W-1:0] HALF_TURN     = 17'sd18000;
  localparam logic signed [ANGLE_W-1:0] NEG_HALF_TURN = -17'sd18000;
  localparam logic signed [ANGLE_W-1:0] FULL_TURN     = 17'sd36000;

  typedef logic signed [ANGLE_W-1:0] angle_t;

  function automatic angle_t atan_entry(input logic [3:0] idx);
    angle_t r;
    case (idx)
      4'd0:    r = 17'sd4500;
      4'd1:    r = 17'sd2657;
      4'd2:    r = 17'sd1404;
      4'd3:    r = 17'sd713;
      4'd4:    r = 17'sd358;
      4'd5:    r = 17'sd179;
      4'd6:    r = 17'sd90;
      4'd7:    r = 17'sd45;
      4'd8:    r = 17'sd22;
      4'd9:    r = 17'sd11;
      4'd10:   r = 17'sd6;
      4'd11:   r = 17'sd3;
      4'd12:   r = 17'sd1;
      4'd13:   r = 17'sd1;
      default: r = 17'sd0;
    endcase
    return r;
  endfunction

endpackage

[sv/cordic_atan2_centidegrees_core.sv]
// ----------------------------------------------------------------------------
// cordic_atan2_centidegrees_core
// Pipelined CORDIC atan2 returning the angle in hundredths of a degree.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | word
//  in      | input     | in_valid / in_ready | in_y_value, in_x_value
//  out     | output    | out_valid/out_ready | out_angle_centideg
//
//  One word accepted per cycle while out_ready stays high. Stages: input fold
//  stage, one cell per vectoring step, wrap/output register.
//  Each stage holds its word while the next one is full and stalled; ready
//  ripples back through the chain of cells in the same cycle.
//  Synchronous active-low reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
module cordic_atan2_centidegrees_core #(
  parameter int ITERATIONS  = cac_pkg::CAC_ITERATIONS,
  parameter int INPUT_WIDTH = cac_pkg::CAC_INPUT_WIDTH
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [INPUT_WIDTH-1:0]           in_y_value,
  input  logic signed [INPUT_WIDTH-1:0]           in_x_value,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [cac_pkg::ANGLE_OUT_W-1:0]  out_angle_centideg
);
  import cac_pkg::*;

  localparam int IW = INPUT_WIDTH + GUARD_BITS;

  logic                 s_valid [0:ITERATIONS];
  logic                 s_ready [0:ITERATIONS];
  logic signed [IW-1:0] s_x     [0:ITERATIONS];
  logic signed [IW-1:0] s_y     [0:ITERATIONS];
  angle_t               s_ang   [0:ITERATIONS];

  cac_prerot #(.INPUT_WIDTH(INPUT_WIDTH), .IW(IW)) u_prerot (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_y      (in_y_value),
    .in_x      (in_x_value),
    .out_valid (s_valid[0]),
    .out_ready (s_ready[0]),
    .out_x     (s_x[0]),
    .out_y     (s_y[0]),
    .out_angle (s_ang[0])
  );

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
    cac_cell #(.IW(IW), .STAGE(i)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (s_valid[i]),
      .in_ready  (s_ready[i]),
      .in_x      (s_x[i]),
      .in_y      (s_y[i]),
      .in_angle  (s_ang[i]),
      .out_valid (s_valid[i+1]),
      .out_ready (s_ready[i+1]),
      .out_x     (s_x[i+1]),
      .out_y     (s_y[i+1]),
      .out_angle (s_ang[i+1])
    );
  end

  cac_wrap u_wrap (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s_valid[ITERATIONS]),
    .in_ready  (s_ready[ITERATIONS]),
    .in_angle  (s_ang[ITERATIONS]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_angle (out_angle_centideg)
  );

endmodule

[sv/cac_prerot.sv]
// ----------------------------------------------------------------------------
// cac_prerot
// Input stage: widen x and y, fold the left half plane and set start angle.
// ----------------------------------------------------------------------------
module cac_prerot #(
  parameter int INPUT_WIDTH = cac_pkg::CAC_INPUT_WIDTH,
  parameter int IW          = INPUT_WIDTH + cac_pkg::GUARD_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [INPUT_WIDTH-1:0] in_y,
  input  logic signed [INPUT_WIDTH-1:0] in_x,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [IW-1:0]          out_x,
  output logic signed [IW-1:0]          out_y,
  output cac_pkg::angle_t               out_angle
);
  import cac_pkg::*;

  logic                 valid_r, valid_nxt;
  logic signed [IW-1:0] x_r, x_nxt, y_r, y_nxt;
  angle_t               ang_r, ang_nxt;
  logic signed [IW-1:0] xw, yw;
  logic                 take;

  assign in_ready = !valid_r || out_ready;
  assign take     = in_valid && in_ready;
  assign xw       = IW'(in_x);
  assign yw       = IW'(in_y);

  always_comb begin
    valid_nxt = valid_r;
    if (out_ready) valid_nxt = 1'b0;
    if (take) valid_nxt = 1'b1;
    if (in_x < 0) begin
      x_nxt   = -xw;
      y_nxt   = -yw;
      ang_nxt = (in_y >= 0) ? HALF_TURN : NEG_HALF_TURN;
    end else begin
      x_nxt   = xw;
      y_nxt   = yw;
      ang_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      ang_r <= ang_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_angle = ang_r;

endmodule

[sv/cac_cell.sv]
// ----------------------------------------------------------------------------
// cac_cell
// One vectoring step: rotate toward the x axis and accumulate the angle.
// ----------------------------------------------------------------------------
module cac_cell #(
  parameter int IW    = cac_pkg::CAC_INPUT_WIDTH + cac_pkg::GUARD_BITS,
  parameter int STAGE = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [IW-1:0] in_x,
  input  logic signed [IW-1:0] in_y,
  input  cac_pkg::angle_t      in_angle,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [IW-1:0] out_x,
  output logic signed [IW-1:0] out_y,
  output cac_pkg::angle_t      out_angle
);
  import cac_pkg::*;

  logic                 valid_r, valid_nxt;
  logic signed [IW-1:0] x_r, x_nxt, y_r, y_nxt;
  angle_t               ang_r, ang_nxt;
  logic signed [IW-1:0] xs, ys;
  angle_t               step;
  logic                 take;

  assign in_ready = !valid_r || out_ready;
  assign take     = in_valid && in_ready;
  assign xs       = in_x >>> STAGE;
  assign ys       = in_y >>> STAGE;
  assign step     = atan_entry(4'(STAGE));

  always_comb begin
    valid_nxt = valid_r;
    if (out_ready) valid_nxt = 1'b0;
    if (take) valid_nxt = 1'b1;
    if (in_y > 0) begin
      x_nxt   = in_x + ys;
      y_nxt   = in_y - xs;
      ang_nxt = in_angle + step;
    end else begin
      x_nxt   = in_x - ys;
      y_nxt   = in_y + xs;
      ang_nxt = in_angle - step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      ang_r <= ang_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_angle = ang_r;

endmodule

[sv/cac_wrap.sv]
// ----------------------------------------------------------------------------
// cac_wrap
// Output stage: wrap the angle into one half turn either side and hold it.
// ----------------------------------------------------------------------------
module cac_wrap (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  cac_pkg::angle_t                         in_angle,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [cac_pkg::ANGLE_OUT_W-1:0]  out_angle
);
  import cac_pkg::*;

  logic                          valid_r, valid_nxt;
  logic signed [ANGLE_OUT_W-1:0] ang_r, ang_nxt;
  angle_t                        wrapped;
  logic                          take;

  assign in_ready = !valid_r || out_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (out_ready) valid_nxt = 1'b0;
    if (take) valid_nxt = 1'b1;
    wrapped = in_angle;
    if (in_angle > HALF_TURN) begin
      wrapped = in_angle - FULL_TURN;
    end else if (in_angle < NEG_HALF_TURN) begin
      wrapped = in_angle + FULL_TURN;
    end
    ang_nxt = wrapped[ANGLE_OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ang_r <= ang_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_angle = ang_r;

endmodule
